>>> rtl/core/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and word helpers for the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int FRAME_W  = 18;
  localparam int COUNT_W  = 19;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int BIT_W    = 5;
  localparam int POP_W    = 6;

  localparam logic [WORD_W-1:0]  FULL_WORD = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 19'h7FFFF;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEAL  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADD,
    S_SEAL,
    S_FREE,
    S_ALLOC,
    S_SETTLE,
    S_DONE
  } bfa_state_t;

  // Counter update request: add a number of freed frames, or drop one.
  typedef struct packed {
    logic             add_en;
    logic             add_total;
    logic [POP_W-1:0] add_n;
    logic             dec_en;
  } bfa_cnt_cmd_t;

  function automatic logic [POP_W-1:0] popcount32(input logic [WORD_W-1:0] w);
    logic [POP_W-1:0] sum;
    sum = '0;
    for (int i = 0; i < WORD_W; i++) begin
      sum = sum + POP_W'(w[i]);
    end
    return sum;
  endfunction

  // Index of the lowest clear bit; the caller makes sure one exists.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Bits lo..hi inclusive set.
  function automatic logic [WORD_W-1:0] span_mask(input logic [BIT_W-1:0] lo,
                                                  input logic [BIT_W-1:0] hi);
    return (FULL_WORD << lo) & (FULL_WORD >> (~hi));
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bitmap_frame_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Used-frame bitmap in one single-port-per-direction RAM with add, seal,
// alloc and free actions and saturating frame counters.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the result sits in an output register so
// the next item can be taken while it waits. After reset a clearing pass
// writes every bitmap word to all-used, with in_stall high. Each action reads
// its first word on the accepting edge; seal and free then write one word,
// add clears the clipped region word by word, and alloc scans word by word,
// starting at the lowest word that can hold a free frame. Out-of-range free,
// add with nothing to clear and alloc once the bitmap is known to be full
// go straight to loading the result. Other results pass a settle state for
// the counters before they are loaded. The next item is taken once the
// result is loaded, later while out_stall holds the previous result. The
// bitmap RAM does one word read and one word write per cycle.
module bitmap_frame_allocator #(
  parameter int FRAMES = 262144
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bfa_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [bfa_pkg::FRAME_W-1:0]   in_frame_number,
  input  wire logic [bfa_pkg::COUNT_W-1:0]   in_frame_count,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bfa_pkg::STATUS_W-1:0]       out_status,
  output logic [bfa_pkg::FRAME_W-1:0]        out_granted_frame,
  output logic [bfa_pkg::COUNT_W-1:0]        out_free_count,
  output logic [bfa_pkg::COUNT_W-1:0]        out_total_count
);
  import bfa_pkg::*;

  localparam int WORDS  = (FRAMES + 31) / 32;
  localparam int WA_W   = $clog2(WORDS);
  localparam int HINT_W = $clog2(WORDS + 1);
  localparam int FLOG   = $clog2(FRAMES);
  localparam int CUR_W  = (FLOG + 1 > 20) ? FLOG + 1 : 20;

  localparam logic [CUR_W-1:0]  FRAMES_C    = CUR_W'(FRAMES);
  localparam logic [HINT_W-1:0] WORDS_C     = HINT_W'(WORDS);
  localparam logic [WA_W-1:0]   LAST_WORD_C = WA_W'(WORDS - 1);

  // Bitmap RAM
  logic [WORD_W-1:0] mem [WORDS];
  logic              mem_we, mem_re;
  logic [WA_W-1:0]   mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Control and working registers
  bfa_state_t         state_r, state_nxt;
  logic [WA_W-1:0]    init_addr_r, init_addr_nxt;
  logic [WA_W-1:0]    wa_r, wa_nxt;
  logic [WA_W-1:0]    sw_r, sw_nxt;
  logic [WA_W-1:0]    ew_r, ew_nxt;
  logic [BIT_W-1:0]   lo_r, lo_nxt;
  logic [BIT_W-1:0]   hi_r, hi_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [HINT_W-1:0]  hint_r, hint_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [FRAME_W-1:0] granted_r, granted_nxt;
  bfa_cnt_cmd_t       cnt_cmd_r, cnt_cmd_nxt;

  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [FRAME_W-1:0] out_granted_r;
  logic [COUNT_W-1:0] out_free_r, out_total_r;
  logic               out_load;

  logic [COUNT_W-1:0] free_count, total_count;

  // Region decode for add, and frame decode for free
  logic [CUR_W-1:0] s_ext, last_raw, last_clip;
  logic             add_range, add_work;

  assign s_ext     = CUR_W'(in_frame_number);
  assign last_raw  = s_ext + CUR_W'(in_frame_count) - CUR_W'(1);
  assign add_range = (in_frame_count != '0) && (last_raw >= FRAMES_C);
  assign add_work  = (in_frame_count != '0) && (s_ext < FRAMES_C);
  assign last_clip = add_range ? (FRAMES_C - CUR_W'(1)) : last_raw;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] flips;
    logic [BIT_W-1:0]  lo, hi, lz;
    logic [CUR_W-1:0]  frame_tmp;

    state_nxt     = state_r;
    init_addr_nxt = init_addr_r;
    wa_nxt        = wa_r;
    sw_nxt        = sw_r;
    ew_nxt        = ew_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bit_nxt       = bit_r;
    hint_nxt      = hint_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    cnt_cmd_nxt   = '0;
    mem_re        = 1'b0;
    mem_raddr     = wa_r;
    mem_we        = 1'b0;
    mem_waddr     = wa_r;
    mem_wdata     = mem_rdata_r;
    out_load      = 1'b0;

    lo        = (wa_r == sw_r) ? lo_r : '0;
    hi        = (wa_r == ew_r) ? hi_r : BIT_W'(WORD_W - 1);
    mask      = span_mask(lo, hi);
    flips     = mem_rdata_r & mask;
    lz        = lowest_zero(mem_rdata_r);
    frame_tmp = CUR_W'({wa_r, lz});

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_addr_r;
        mem_wdata = FULL_WORD;
        if (init_addr_r == LAST_WORD_C) begin
          state_nxt = S_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + WA_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          status_nxt  = ST_OK;
          granted_nxt = '0;
          bit_nxt     = in_frame_number[BIT_W-1:0];
          unique case (in_action)
            ACT_ADD: begin
              status_nxt = add_range ? ST_RANGE : ST_OK;
              if (add_work) begin
                mem_re    = 1'b1;
                mem_raddr = s_ext[WA_W+4:5];
                wa_nxt    = s_ext[WA_W+4:5];
                sw_nxt    = s_ext[WA_W+4:5];
                ew_nxt    = last_clip[WA_W+4:5];
                lo_nxt    = s_ext[BIT_W-1:0];
                hi_nxt    = last_clip[BIT_W-1:0];
                if (HINT_W'(s_ext[WA_W+4:5]) < hint_r) begin
                  hint_nxt = HINT_W'(s_ext[WA_W+4:5]);
                end
                state_nxt = S_ADD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            ACT_SEAL: begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              wa_nxt    = '0;
              state_nxt = S_SEAL;
            end
            ACT_ALLOC: begin
              if (hint_r == WORDS_C) begin
                status_nxt = ST_OOM;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = hint_r[WA_W-1:0];
                wa_nxt    = hint_r[WA_W-1:0];
                state_nxt = S_ALLOC;
              end
            end
            ACT_FREE: begin
              if (s_ext >= FRAMES_C) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = s_ext[WA_W+4:5];
                wa_nxt    = s_ext[WA_W+4:5];
                state_nxt = S_FREE;
              end
            end
          endcase
        end
      end

      S_ADD: begin
        // Clear the span in this word; count only bits that flip.
        mem_we                = 1'b1;
        mem_wdata             = mem_rdata_r & ~mask;
        cnt_cmd_nxt.add_en    = 1'b1;
        cnt_cmd_nxt.add_total = 1'b1;
        cnt_cmd_nxt.add_n     = popcount32(flips);
        if (wa_r == ew_r) begin
          state_nxt = S_SETTLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wa_r + WA_W'(1);
          wa_nxt    = wa_r + WA_W'(1);
        end
      end

      S_SEAL: begin
        if (!mem_rdata_r[0]) begin
          mem_we             = 1'b1;
          mem_wdata          = mem_rdata_r | WORD_W'(1);
          cnt_cmd_nxt.dec_en = 1'b1;
        end
        state_nxt = S_SETTLE;
      end

      S_FREE: begin
        if (!mem_rdata_r[bit_r]) begin
          status_nxt = ST_DOUBLE;
        end else begin
          mem_we            = 1'b1;
          mem_wdata         = mem_rdata_r & ~(WORD_W'(1) << bit_r);
          cnt_cmd_nxt.add_en = 1'b1;
          cnt_cmd_nxt.add_n  = POP_W'(1);
          if (HINT_W'(wa_r) < hint_r) begin
            hint_nxt = HINT_W'(wa_r);
          end
        end
        state_nxt = S_SETTLE;
      end

      S_ALLOC: begin
        // One word per cycle; the read of the next word is issued while this one is checked.
        if (mem_rdata_r != FULL_WORD) begin
          mem_we             = 1'b1;
          mem_wdata          = mem_rdata_r | (WORD_W'(1) << lz);
          cnt_cmd_nxt.dec_en = 1'b1;
          granted_nxt        = frame_tmp[FRAME_W-1:0];
          hint_nxt           = HINT_W'(wa_r);
          state_nxt          = S_SETTLE;
        end else if (wa_r == LAST_WORD_C) begin
          status_nxt = ST_OOM;
          hint_nxt   = WORDS_C;
          state_nxt  = S_SETTLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wa_r + WA_W'(1);
          wa_nxt    = wa_r + WA_W'(1);
        end
      end

      S_SETTLE: begin
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_addr_r <= '0;
      hint_r      <= WORDS_C;
      cnt_cmd_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_addr_r <= init_addr_nxt;
      hint_r      <= hint_nxt;
      cnt_cmd_r   <= cnt_cmd_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wa_r      <= wa_nxt;
    sw_r      <= sw_nxt;
    ew_r      <= ew_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    bit_r     <= bit_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_granted_r <= granted_r;
      out_free_r    <= free_count;
      out_total_r   <= total_count;
    end
  end

  bfa_counters u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cnt_cmd_r),
    .free_count  (free_count),
    .total_count (total_count)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_frame = out_granted_r;
  assign out_free_count    = out_free_r;
  assign out_total_count   = out_total_r;

`ifndef NO_ASSERTIONS
  a_no_same_word_rw: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("bitmap read and write hit the same word in one cycle");

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= WORDS_C)
    else $error("search hint beyond the bitmap");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_granted_frame == '0))
    else $error("frame granted with a failing status");

  a_alloc_flips_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && mem_we) |-> (mem_wdata != mem_rdata_r))
    else $error("alloc wrote back an unchanged word");

  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cnt_cmd_r.add_en && !cnt_cmd_r.dec_en) |=> $stable(free_count) && $stable(total_count))
    else $error("counters moved without a command");
`endif

endmodule
`default_nettype wire

>>> rtl/core/bfa_counters.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_counters
// Saturating free and total frame counters, driven by one command per cycle.
// ----------------------------------------------------------------------------
module bfa_counters (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bfa_pkg::bfa_cnt_cmd_t        cmd,
  output logic [bfa_pkg::COUNT_W-1:0]       free_count,
  output logic [bfa_pkg::COUNT_W-1:0]       total_count
);
  import bfa_pkg::*;

  logic [COUNT_W-1:0] free_r, free_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [COUNT_W:0]   free_sum, total_sum;

  assign free_sum  = {1'b0, free_r} + (COUNT_W + 1)'(cmd.add_n);
  assign total_sum = {1'b0, total_r} + (COUNT_W + 1)'(cmd.add_n);

  always_comb begin
    free_nxt  = free_r;
    total_nxt = total_r;
    if (cmd.add_en) begin
      free_nxt = (free_sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : free_sum[COUNT_W-1:0];
      if (cmd.add_total) begin
        total_nxt = (total_sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX
                                                             : total_sum[COUNT_W-1:0];
      end
    end else if (cmd.dec_en && free_r != '0) begin
      free_nxt = free_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= '0;
      total_r <= '0;
    end else begin
      free_r  <= free_nxt;
      total_r <= total_nxt;
    end
  end

  assign free_count  = free_r;
  assign total_count = total_r;

endmodule
`default_nettype wire
